>>> rtl/swhsr_pkg.sv
// ----------------------------------------------------------------------------
// swhsr_pkg
// Shared codes and constants for the single-wire humidity sensor reader:
// sequencer phase codes, result status codes, register indexes and widths.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_WARM   = 4'd1;
  localparam logic [3:0] PH_LOW    = 4'd2;
  localparam logic [3:0] PH_HIGH   = 4'd3;
  localparam logic [3:0] PH_SETTLE = 4'd4;
  localparam logic [3:0] PH_RLOW   = 4'd5;
  localparam logic [3:0] PH_RHIGH  = 4'd6;
  localparam logic [3:0] PH_BLOW   = 4'd7;
  localparam logic [3:0] PH_BHIGH  = 4'd8;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_WARMUP       = 3'd0;
  localparam logic [2:0] REG_START_LOW    = 3'd1;
  localparam logic [2:0] REG_RELEASE_HIGH = 3'd2;
  localparam logic [2:0] REG_SETTLE       = 3'd3;
  localparam logic [2:0] REG_RESP_LIMIT   = 3'd4;
  localparam logic [2:0] REG_BLOW_LIMIT   = 3'd5;
  localparam logic [2:0] REG_BHIGH_LIMIT  = 3'd6;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd7;

  // Register reset values.
  localparam logic [19:0] WARMUP_RST       = 20'd250000;
  localparam logic [16:0] START_LOW_RST    = 17'd20000;
  localparam logic [7:0]  RELEASE_HIGH_RST = 8'd40;
  localparam logic [7:0]  SETTLE_RST       = 8'd10;
  localparam logic [6:0]  RESP_LIMIT_RST   = 7'd80;
  localparam logic [6:0]  BLOW_LIMIT_RST   = 7'd55;
  localparam logic [6:0]  BHIGH_LIMIT_RST  = 7'd75;
  localparam logic [21:0] MIN_INTERVAL_RST = 22'd2000000;

  // Frame layout and counter limits.
  localparam int unsigned FRAME_BITS = 40;
  localparam logic [5:0]  LAST_BIT   = 6'd40;
  localparam logic [6:0]  COUNT_MAX  = 7'd127;
  localparam logic [6:0]  LIMIT_MAX  = 7'd126;
  localparam logic [21:0] SINCE_MAX  = 22'h3FFFFF;

  typedef logic [FRAME_BITS-1:0] frame_t;

endpackage

>>> rtl/single_wire_humidity_sensor_reader.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Tick-driven sequencer for a single-wire humidity/temperature sensor: drives
// the start sequence, times the response and 40 data bits, checks the sum.
// ----------------------------------------------------------------------------
// The result for a tick is registered: it appears on the out_ ports in the cycle
// after the tick is accepted, from a single output register.
// Throughput: one tick per cycle; a new tick is taken whenever the output
// register is empty or being read in the same cycle.
// Reset (rst_n low, synchronous): sequencer idle, counters cleared, held data
// zero, registers at defaults, and the first read request is always allowed.
module single_wire_humidity_sensor_reader
  import swhsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Tick input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_line_level,
  input  logic        in_start_request,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_enable,
  output logic        out_drive_level,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic        out_fresh,
  output logic [7:0]  out_humidity_int,
  output logic [7:0]  out_humidity_frac,
  output logic [7:0]  out_temperature_int,
  output logic [7:0]  out_temperature_frac,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  // Configuration registers
  logic [19:0] warmup_r;
  logic [16:0] start_low_r;
  logic [7:0]  release_high_r;
  logic [7:0]  settle_r;
  logic [6:0]  resp_limit_r;
  logic [6:0]  blow_limit_r;
  logic [6:0]  bhigh_limit_r;
  logic [21:0] min_interval_r;

  // Sequencer state
  logic [3:0]  phase_r,     phase_nxt;
  logic [19:0] timer_r,     timer_nxt;
  logic [6:0]  count_r,     count_nxt;
  logic [6:0]  low_len_r,   low_len_nxt;
  frame_t      frame_r,     frame_nxt;
  logic [5:0]  bit_idx_r,   bit_idx_nxt;
  logic [21:0] since_r,     since_nxt;
  frame_t      held_r,      held_nxt;

  // Output register
  logic        out_valid_r;
  logic        drv_en_r,    drv_en_nxt;
  logic        drv_lvl_r,   drv_lvl_nxt;
  logic        done_r,      done_nxt;
  logic [1:0]  status_r,    status_nxt;
  logic        fresh_r,     fresh_nxt;
  frame_t      bytes_r,     bytes_nxt;

  logic        accept;

  // A tick is taken whenever the output register can take its result.
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes; each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r       <= WARMUP_RST;
      start_low_r    <= START_LOW_RST;
      release_high_r <= RELEASE_HIGH_RST;
      settle_r       <= SETTLE_RST;
      resp_limit_r   <= RESP_LIMIT_RST;
      blow_limit_r   <= BLOW_LIMIT_RST;
      bhigh_limit_r  <= BHIGH_LIMIT_RST;
      min_interval_r <= MIN_INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WARMUP:       warmup_r       <= cfg_data[19:0];
        REG_START_LOW:    start_low_r    <= cfg_data[16:0];
        REG_RELEASE_HIGH: release_high_r <= cfg_data[7:0];
        REG_SETTLE:       settle_r       <= cfg_data[7:0];
        REG_RESP_LIMIT:   resp_limit_r   <= cfg_data[6:0];
        REG_BLOW_LIMIT:   blow_limit_r   <= cfg_data[6:0];
        REG_BHIGH_LIMIT:  bhigh_limit_r  <= cfg_data[6:0];
        REG_MIN_INTERVAL: min_interval_r <= cfg_data[21:0];
        default:          ;
      endcase
    end
  end

  // Per-tick next state and result.
  always_comb begin
    logic [3:0]  ph;
    logic [19:0] tmr;
    logic [19:0] step_len;
    logic        want;
    logic [6:0]  lim_raw;
    logic [6:0]  lim;
    logic        bit_val;
    frame_t      frame_new;
    logic [7:0]  sum;

    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    count_nxt   = count_r;
    low_len_nxt = low_len_r;
    frame_nxt   = frame_r;
    bit_idx_nxt = bit_idx_r;
    held_nxt    = held_r;
    since_nxt   = (since_r != SINCE_MAX) ? since_r + 22'd1 : since_r;

    drv_en_nxt  = 1'b0;
    drv_lvl_nxt = 1'b0;
    done_nxt    = 1'b0;
    status_nxt  = ST_OK;
    fresh_nxt   = 1'b0;
    bytes_nxt   = '0;

    ph        = phase_r;
    tmr       = timer_r;
    step_len  = '0;
    want      = 1'b0;
    lim_raw   = '0;
    lim       = '0;
    bit_val   = 1'b0;
    frame_new = frame_r;
    sum       = '0;

    if (phase_r == PH_IDLE) begin
      // Idle: a request either reuses held data or launches a real read.
      if (in_start_request) begin
        if (since_r < min_interval_r) begin
          done_nxt   = 1'b1;
          status_nxt = ST_OK;
          fresh_nxt  = 1'b0;
          bytes_nxt  = held_r;
        end else begin
          since_nxt   = '0;
          held_nxt    = '0;
          frame_nxt   = '0;
          bit_idx_nxt = '0;
          count_nxt   = '0;
          low_len_nxt = '0;
          timer_nxt   = '0;
          phase_nxt   = PH_WARM;
        end
      end
    end else begin
      // Length of the current start-sequence step.
      unique case (phase_r)
        PH_WARM:   step_len = warmup_r;
        PH_LOW:    step_len = {3'd0, start_low_r};
        PH_HIGH:   step_len = {12'd0, release_high_r};
        PH_SETTLE: step_len = {12'd0, settle_r};
        default:   step_len = '0;
      endcase

      // An expired step moves on, skipping any later step of zero length.
      if (phase_r >= PH_WARM && phase_r <= PH_SETTLE && timer_r >= step_len) begin
        tmr = '0;
        priority if (phase_r == PH_WARM && start_low_r != '0) ph = PH_LOW;
        else if (phase_r <= PH_LOW && release_high_r != '0)    ph = PH_HIGH;
        else if (phase_r <= PH_HIGH && settle_r != '0)         ph = PH_SETTLE;
        else                                                   ph = PH_RLOW;
      end

      if (ph >= PH_WARM && ph <= PH_SETTLE) begin
        // Start sequence: drive low, then high, otherwise release.
        phase_nxt   = ph;
        timer_nxt   = tmr + 20'd1;
        drv_en_nxt  = (ph == PH_LOW) || (ph == PH_HIGH);
        drv_lvl_nxt = (ph == PH_HIGH);
      end else if (ph >= PH_RLOW && ph <= PH_BHIGH) begin
        // Response and bit timing on the sampled line.
        phase_nxt = ph;
        timer_nxt = tmr;
        want      = (ph == PH_RHIGH) || (ph == PH_BHIGH);
        unique case (ph)
          PH_BLOW:  lim_raw = blow_limit_r;
          PH_BHIGH: lim_raw = bhigh_limit_r;
          default:  lim_raw = resp_limit_r;
        endcase
        lim = (lim_raw > LIMIT_MAX) ? LIMIT_MAX : lim_raw;

        if (in_line_level == want) begin
          // Same level: extend the phase or time out.
          if (count_r > lim) begin
            phase_nxt  = PH_IDLE;
            done_nxt   = 1'b1;
            status_nxt = ST_TIMEOUT;
            fresh_nxt  = 1'b1;
            bytes_nxt  = held_r;
          end else if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 7'd1;
          end
        end else begin
          // Level change: this sample is the first of the next phase.
          count_nxt = 7'd1;
          unique case (ph)
            PH_RLOW:  phase_nxt = PH_RHIGH;
            PH_RHIGH: phase_nxt = PH_BLOW;
            PH_BLOW: begin
              low_len_nxt = count_r;
              phase_nxt   = PH_BHIGH;
            end
            PH_BHIGH: begin
              bit_val     = (count_r > low_len_r);
              frame_new   = {frame_r[FRAME_BITS-2:0], bit_val};
              frame_nxt   = frame_new;
              bit_idx_nxt = bit_idx_r + 6'd1;
              count_nxt   = '0;
              if (bit_idx_nxt >= LAST_BIT) begin
                // Frame complete: hold the bytes and check the sum.
                sum        = frame_new[39:32] + frame_new[31:24]
                           + frame_new[23:16] + frame_new[15:8];
                held_nxt   = frame_new;
                phase_nxt  = PH_IDLE;
                done_nxt   = 1'b1;
                status_nxt = (sum == frame_new[7:0]) ? ST_OK : ST_CHECKSUM;
                fresh_nxt  = 1'b1;
                bytes_nxt  = frame_new;
              end else begin
                phase_nxt = PH_BLOW;
                count_nxt = 7'd1;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
      end else begin
        // Codes outside the sequence fall back to idle.
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Sequencer state update on each accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      count_r   <= '0;
      low_len_r <= '0;
      frame_r   <= '0;
      bit_idx_r <= '0;
      since_r   <= SINCE_MAX;
      held_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      count_r   <= count_nxt;
      low_len_r <= low_len_nxt;
      frame_r   <= frame_nxt;
      bit_idx_r <= bit_idx_nxt;
      since_r   <= since_nxt;
      held_r    <= held_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      drv_en_r  <= drv_en_nxt;
      drv_lvl_r <= drv_lvl_nxt;
      done_r    <= done_nxt;
      status_r  <= status_nxt;
      fresh_r   <= fresh_nxt;
      bytes_r   <= bytes_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive_enable     = drv_en_r;
  assign out_drive_level      = drv_lvl_r;
  assign out_done_res         = done_r;
  assign out_status           = status_r;
  assign out_fresh            = fresh_r;
  assign out_humidity_int     = bytes_r[39:32];
  assign out_humidity_frac    = bytes_r[31:24];
  assign out_temperature_int  = bytes_r[23:16];
  assign out_temperature_frac = bytes_r[15:8];

endmodule

>>> rtl/swhsr_checker.sv
// ----------------------------------------------------------------------------
// swhsr_checker
// Port-level checks for the single-wire humidity sensor reader, bound to the
// top level.
// ----------------------------------------------------------------------------
module swhsr_checker
  import swhsr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_line_level,
  input logic        in_start_request,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_drive_enable,
  input logic        out_drive_level,
  input logic        out_done_res,
  input logic [1:0]  out_status,
  input logic        out_fresh,
  input logic [7:0]  out_humidity_int,
  input logic [7:0]  out_humidity_frac,
  input logic [7:0]  out_temperature_int,
  input logic [7:0]  out_temperature_frac,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [21:0] cfg_data
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_done_res)
      && $stable(out_status) && $stable(out_humidity_int))
    else $error("result changed while stalled");

  // Without a completion every report field reads zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK && !out_fresh
      && out_humidity_int == 8'd0 && out_humidity_frac == 8'd0
      && out_temperature_int == 8'd0 && out_temperature_frac == 8'd0)
    else $error("report fields set without completion");

  // The status code is always a defined one.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_TIMEOUT
      || out_status == ST_CHECKSUM)
    else $error("undefined status code");

  // A released line carries a low drive level, and no completion drives it high.
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_drive_enable || out_done_res) |-> !out_drive_level)
    else $error("drive level set while released");

  // Reuse of held data always reports success.
  a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && !out_fresh |-> out_status == ST_OK
      && !out_drive_enable)
    else $error("held-data reuse reported an error");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (.*);

>>> test/single_wire_humidity_sensor_reader_test.sv
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_test
// Self-checking bench for the single-wire sensor reader. It feeds one line
// sample per request and predicts every result with its own sequencer model,
// including drive levels, timeouts, checksum errors and reuse of held data.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_test
  import swhsr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One result as it leaves the block, in port order.
  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       done_res;
    logic [1:0] status;
    logic       fresh;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temperature_int;
    logic [7:0] temperature_frac;
  } reading_t;

  // Sequencer predictor plus the store of readings still to arrive.
  class reading_scoreboard;
    logic [21:0] regs [8];
    logic [3:0]  phase;
    int unsigned step_timer;
    logic [6:0]  level_count;
    logic [6:0]  low_len;
    logic [39:0] frame;
    logic [5:0]  bit_count;
    logic [21:0] since_read;
    logic [39:0] held;
    reading_t    expected_readings [$];
    int          errors;
    int          good_reads;
    int          sum_errors;
    int          timeouts;
    int          reuses;

    function new();
      regs[REG_WARMUP]       = 22'(WARMUP_RST);
      regs[REG_START_LOW]    = 22'(START_LOW_RST);
      regs[REG_RELEASE_HIGH] = 22'(RELEASE_HIGH_RST);
      regs[REG_SETTLE]       = 22'(SETTLE_RST);
      regs[REG_RESP_LIMIT]   = 22'(RESP_LIMIT_RST);
      regs[REG_BLOW_LIMIT]   = 22'(BLOW_LIMIT_RST);
      regs[REG_BHIGH_LIMIT]  = 22'(BHIGH_LIMIT_RST);
      regs[REG_MIN_INTERVAL] = MIN_INTERVAL_RST;
      phase = PH_IDLE;
      step_timer = 0;
      level_count = '0;
      low_len = '0;
      frame = '0;
      bit_count = '0;
      since_read = SINCE_MAX;
      held = '0;
      errors = 0;
      good_reads = 0;
      sum_errors = 0;
      timeouts = 0;
      reuses = 0;
    endfunction

    // Registers keep only as many bits as they are wide.
    function void set_reg(logic [2:0] idx, logic [21:0] data);
      case (idx)
        REG_WARMUP:       regs[idx] = 22'(data[19:0]);
        REG_START_LOW:    regs[idx] = 22'(data[16:0]);
        REG_RELEASE_HIGH,
        REG_SETTLE:       regs[idx] = 22'(data[7:0]);
        REG_RESP_LIMIT,
        REG_BLOW_LIMIT,
        REG_BHIGH_LIMIT:  regs[idx] = 22'(data[6:0]);
        default:          regs[idx] = data;
      endcase
    endfunction

    // Effective sample-count limit; anything above 126 acts as 126.
    function int limit(logic [2:0] idx);
      return (regs[idx] > 22'(LIMIT_MAX)) ? int'(LIMIT_MAX) : int'(regs[idx]);
    endfunction

    function bit start_step(logic [3:0] p);
      return (p >= PH_WARM) && (p <= PH_SETTLE);
    endfunction

    function logic [21:0] step_len(logic [3:0] p);
      case (p)
        PH_WARM: return regs[REG_WARMUP];
        PH_LOW:  return regs[REG_START_LOW];
        PH_HIGH: return regs[REG_RELEASE_HIGH];
        default: return regs[REG_SETTLE];
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    // True when the next sample still falls inside the start sequence.
    function bit starting();
      logic [3:0]  p;
      int unsigned t;
      p = phase;
      t = step_timer;
      while (start_step(p) && t >= step_len(p)) begin
        p++;
        t = 0;
      end
      return start_step(p);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // Completion result carrying the held bytes.
    function reading_t finish(logic [1:0] st, logic fr);
      reading_t r;
      r = '0;
      r.done_res = 1'b1;
      r.status = st;
      r.fresh = fr;
      r.humidity_int = held[39:32];
      r.humidity_frac = held[31:24];
      r.temperature_int = held[23:16];
      r.temperature_frac = held[15:8];
      if (!fr) reuses++;
      else if (st == ST_TIMEOUT) timeouts++;
      else if (st == ST_CHECKSUM) sum_errors++;
      else good_reads++;
      return r;
    endfunction

    // Counts a sample at the phase's level; true once it overruns the limit.
    function bit over_limit(logic [2:0] idx);
      if (int'(level_count) > limit(idx)) return 1'b1;
      if (level_count < COUNT_MAX) level_count++;
      return 1'b0;
    endfunction

    // Advances the sequencer by one accepted line sample.
    function void note_tick(logic lvl, logic req);
      reading_t    r;
      logic [21:0] since;
      logic [7:0]  sum;
      bit          settled;
      r = '0;
      since = since_read;
      if (since_read != SINCE_MAX) since_read++;

      if (phase == PH_IDLE) begin
        if (req) begin
          if (since < regs[REG_MIN_INTERVAL]) begin
            r = finish(ST_OK, 1'b0);
          end else begin
            since_read = '0;
            held = '0;
            frame = '0;
            bit_count = '0;
            level_count = '0;
            low_len = '0;
            step_timer = 0;
            phase = PH_WARM;
          end
        end
        expected_readings.push_back(r);
        return;
      end

      // Start sequence: empty steps are skipped on the same sample.
      while (start_step(phase) && step_timer >= step_len(phase)) begin
        phase++;
        step_timer = 0;
      end
      if (start_step(phase)) begin
        r.drive_enable = (phase == PH_LOW) || (phase == PH_HIGH);
        r.drive_level = (phase == PH_HIGH);
        step_timer++;
        expected_readings.push_back(r);
        return;
      end

      // Sampling: the sample that ends a phase also opens the next one.
      settled = 1'b0;
      while (!settled) begin
        case (phase)
          PH_RLOW, PH_RHIGH: begin
            if (lvl == (phase == PH_RHIGH)) begin
              settled = 1'b1;
              if (over_limit(REG_RESP_LIMIT)) begin
                phase = PH_IDLE;
                r = finish(ST_TIMEOUT, 1'b1);
              end
            end else begin
              phase = (phase == PH_RLOW) ? PH_RHIGH : PH_BLOW;
              level_count = '0;
            end
          end
          PH_BLOW: begin
            if (!lvl) begin
              settled = 1'b1;
              if (over_limit(REG_BLOW_LIMIT)) begin
                phase = PH_IDLE;
                r = finish(ST_TIMEOUT, 1'b1);
              end
            end else begin
              low_len = level_count;
              phase = PH_BHIGH;
              level_count = '0;
            end
          end
          PH_BHIGH: begin
            if (lvl) begin
              settled = 1'b1;
              if (over_limit(REG_BHIGH_LIMIT)) begin
                phase = PH_IDLE;
                r = finish(ST_TIMEOUT, 1'b1);
              end
            end else begin
              frame = {frame[38:0], level_count > low_len};
              bit_count++;
              level_count = '0;
              if (bit_count >= LAST_BIT) begin
                held = frame;
                sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                phase = PH_IDLE;
                r = finish((sum == frame[7:0]) ? ST_OK : ST_CHECKSUM, 1'b1);
                settled = 1'b1;
              end else begin
                phase = PH_BLOW;
              end
            end
          end
          default: begin
            phase = PH_IDLE;
            settled = 1'b1;
          end
        endcase
      end
      expected_readings.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result against the oldest prediction.
    function void check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      compare("drive_enable", 8'(want.drive_enable), 8'(got.drive_enable));
      compare("drive_level", 8'(want.drive_level), 8'(got.drive_level));
      compare("done_res", 8'(want.done_res), 8'(got.done_res));
      compare("status", 8'(want.status), 8'(got.status));
      compare("fresh", 8'(want.fresh), 8'(got.fresh));
      compare("humidity_int", want.humidity_int, got.humidity_int);
      compare("humidity_frac", want.humidity_frac, got.humidity_frac);
      compare("temperature_int", want.temperature_int, got.temperature_int);
      compare("temperature_frac", want.temperature_frac, got.temperature_frac);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_line_level;
  logic        in_start_request;
  logic        out_valid;
  logic        out_stall;
  logic        out_drive_enable;
  logic        out_drive_level;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic        out_fresh;
  logic [7:0]  out_humidity_int;
  logic [7:0]  out_humidity_frac;
  logic [7:0]  out_temperature_int;
  logic [7:0]  out_temperature_frac;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_data;

  reading_scoreboard sb;
  int                ticks_sent;
  bit                steady;

  single_wire_humidity_sensor_reader uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_line_level        (in_line_level),
    .in_start_request     (in_start_request),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_drive_enable     (out_drive_enable),
    .out_drive_level      (out_drive_level),
    .out_done_res         (out_done_res),
    .out_status           (out_status),
    .out_fresh            (out_fresh),
    .out_humidity_int     (out_humidity_int),
    .out_humidity_frac    (out_humidity_frac),
    .out_temperature_int  (out_temperature_int),
    .out_temperature_frac (out_temperature_frac),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int shorter(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // Offers one line sample request and waits until the block takes it.
  task automatic send_tick(input logic lvl, input logic req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_level <= lvl;
    in_start_request <= req;
    do @(posedge clk); while (in_stall);
    sb.note_tick(lvl, req);
    ticks_sent++;
  endtask

  // Holds the line at one level for up to n samples, stopping once the read ends.
  task automatic send_run(input logic lvl, input int n);
    for (int i = 0; i < n && sb.busy(); i++)
      send_tick(lvl, $urandom_range(0, 15) == 0);
  endtask

  // Lets a read in progress run out with the line released high.
  task automatic finish_read();
    while (sb.busy()) send_tick(1'b1, 1'b0);
  endtask

  // Stops offering requests until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Rewrites all registers once the sequencer and the pipeline are idle.
  task automatic reconfigure(input logic [21:0] vals [8]);
    finish_read();
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [21:0] pick_limit();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 22'd0;
    if (r == 1) return 22'(LIMIT_MAX);
    if (r == 2) return 22'(COUNT_MAX);
    return 22'($urandom_range(1, 8));
  endfunction

  // Short start steps, mostly small limits; the first pass takes the extremes.
  task automatic reconfigure_random(input bit extremes);
    logic [21:0] vals [8];
    int          r;
    vals[REG_WARMUP] = 22'($urandom_range(0, 4));
    vals[REG_START_LOW] = 22'($urandom_range(0, 4));
    vals[REG_RELEASE_HIGH] = ($urandom_range(0, 9) == 0) ? 22'd255 : 22'($urandom_range(0, 4));
    vals[REG_SETTLE] = ($urandom_range(0, 9) == 0) ? 22'd255 : 22'($urandom_range(0, 4));
    vals[REG_RESP_LIMIT] = pick_limit();
    vals[REG_BLOW_LIMIT] = pick_limit();
    vals[REG_BHIGH_LIMIT] = pick_limit();
    r = $urandom_range(0, 9);
    if (r < 3) vals[REG_MIN_INTERVAL] = 22'd0;
    else if (r < 9) vals[REG_MIN_INTERVAL] = 22'($urandom_range(50, 600));
    else vals[REG_MIN_INTERVAL] = 22'd4000000;
    if (extremes) begin
      vals[REG_RELEASE_HIGH] = 22'd255;
      vals[REG_SETTLE] = 22'd255;
      vals[REG_RESP_LIMIT] = 22'(LIMIT_MAX);
      vals[REG_BLOW_LIMIT] = 22'(COUNT_MAX);
      vals[REG_BHIGH_LIMIT] = 22'(COUNT_MAX);
      vals[REG_MIN_INTERVAL] = 22'd0;
    end
    reconfigure(vals);
  endtask

  // Length of a response phase; an injected fault overruns the limit by one.
  function automatic int response_len(bit overrun);
    int lim;
    lim = sb.limit(REG_RESP_LIMIT);
    if (overrun) return lim + 2;
    if ($urandom_range(0, 19) == 0) return lim + 1;
    return $urandom_range(1, shorter(lim + 1, 4));
  endfunction

  // One sensor answer: request, start sequence, response and 40 timed bits.
  task automatic read_frame();
    logic [7:0]  b [5];
    logic [39:0] bits;
    int          inject;
    int          liml;
    int          limh;
    int          lo_max;
    int          lo_len;
    int          hi_len;
    send_tick(1'($urandom_range(0, 1)), 1'b1);
    if (!sb.busy()) return;
    while (sb.starting()) send_tick(1'($urandom_range(0, 1)), 1'b0);

    for (int i = 0; i < 4; i++) b[i] = 8'($urandom);
    b[4] = b[0] + b[1] + b[2] + b[3];
    if ($urandom_range(0, 3) == 0) b[4] = 8'($urandom);
    bits = {b[0], b[1], b[2], b[3], b[4]};
    inject = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 81) : -1;
    liml = sb.limit(REG_BLOW_LIMIT);
    limh = sb.limit(REG_BHIGH_LIMIT);
    lo_max = shorter(liml + 1, 3);

    send_run(1'b0, response_len(inject == 0));
    send_run(1'b1, response_len(inject == 1));
    for (int k = 0; k < 40; k++) begin
      // A one needs a high phase longer than its low phase.
      if (bits[39 - k] && limh >= 1) begin
        lo_len = $urandom_range(1, shorter(lo_max, limh));
        hi_len = $urandom_range(lo_len + 1, shorter(limh + 1, lo_len + 3));
      end else begin
        lo_len = $urandom_range(1, lo_max);
        hi_len = $urandom_range(1, shorter(lo_len, limh + 1));
      end
      if (inject == 2 + 2 * k) lo_len = liml + 2;
      if (inject == 3 + 2 * k) hi_len = limh + 2;
      send_run(1'b0, lo_len);
      send_run(1'b1, hi_len);
    end
    // The falling edge after the last bit completes the read.
    send_run(1'b0, 1);
  endtask

  // Result side: random stalls, one long hold-off, and checking.
  initial begin
    int stall_left;
    int accepted;
    bit held_off;
    out_stall = 1'b0;
    stall_left = 0;
    accepted = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_reading({out_drive_enable, out_drive_level, out_done_res, out_status,
                          out_fresh, out_humidity_int, out_humidity_frac,
                          out_temperature_int, out_temperature_frac});
        accepted++;
        stall_left = steady ? 0 : $urandom_range(0, 3);
        if (!held_off && accepted >= 400 && in_valid) begin
          stall_left = 150;
          held_off = 1'b1;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [21:0] vals [8];
    int          random_end;
    int          episode;
    int          kind;
    sb = new();
    ticks_sent = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_line_level = 1'b0;
    in_start_request = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Idle samples at both line levels under the reset settings.
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);

    // Every step empty and every limit zero: sampling starts right after the
    // accepted request, a request while busy is ignored, and the response
    // low phase times out.
    foreach (vals[i]) vals[i] = '0;
    reconfigure(vals);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Long steps and interval: early requests reuse the cleared held bytes.
    vals[REG_WARMUP] = 22'd1000000;
    vals[REG_START_LOW] = 22'd100000;
    vals[REG_MIN_INTERVAL] = 22'd4000000;
    reconfigure(vals);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);

    // One tick per start step, so the driven-low and driven-high patterns each appear once.
    vals[REG_WARMUP] = 22'd1;
    vals[REG_START_LOW] = 22'd1;
    vals[REG_RELEASE_HIGH] = 22'd1;
    vals[REG_SETTLE] = 22'd1;
    vals[REG_RESP_LIMIT] = 22'd1;
    vals[REG_MIN_INTERVAL] = 22'd0;
    reconfigure(vals);
    send_tick(1'b1, 1'b1);
    finish_read();

    // Random part: mostly whole frames, some reuse requests, some noise.
    random_end = ticks_sent + 850;
    episode = 0;
    while (ticks_sent < random_end) begin
      steady = ($urandom_range(0, 3) == 0);
      if (episode == 0 || $urandom_range(0, 3) == 0)
        reconfigure_random(episode == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        read_frame();
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 3)) begin
          send_tick(1'($urandom_range(0, 1)), 1'b1);
          send_run(1'($urandom_range(0, 1)), 2);
        end
      end else begin
        repeat ($urandom_range(5, 30))
          send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end
      finish_read();
      episode++;
    end

    steady = 1'b0;
    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d line samples in %0d random episodes after the directed cases.",
             ticks_sent, episode);
    $display("Reads: %0d good, %0d checksum errors, %0d timeouts, %0d held-data reuses.",
             sb.good_reads, sb.sum_errors, sb.timeouts, sb.reuses);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
